// ===== hw/rtl/fpa_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
package fpa_pkg;

	typedef enum logic [3:0] {
		KIND_ADD  = 4'd0,
		KIND_SUB  = 4'd1,
		KIND_MUL  = 4'd2,
		KIND_DIV  = 4'd3,
		KIND_MIN  = 4'd4,
		KIND_MAX  = 4'd5,
		KIND_INC  = 4'd6,
		KIND_DEC  = 4'd7,
		KIND_FINT = 4'd8
	} kind_t;

	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// Everything an item carries alongside the divider.
	typedef struct packed {
		logic        is_mul;
		logic        is_div;
		logic        div_neg;
		logic        div_zero;
		logic [31:0] result;
		logic        ovf;
		logic        less;
		logic        greater;
		logic        equal;
		logic [23:0] int_part;
	} side_t;

endpackage

// ===== hw/rtl/fpa_front.sv =====
// Input stage: simple operations, comparisons, multiplier and divider operand setup.
module fpa_front #(
	parameter int FB = 8,
	parameter int NW = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [3:0]           kind,
	input  logic signed [31:0]   operand_a,
	input  logic signed [31:0]   operand_b,
	output logic                 valid_s1,
	output fpa_pkg::side_t       side_s1,
	output logic signed [63:0]   prod_s1,
	output logic [NW-1:0]        num_s1,
	output logic [31:0]          den_s1
);
	import fpa_pkg::*;

	side_t       side_d;
	logic [32:0] add_w;
	logic [32:0] sub_w;
	logic [FB:0] fint_top;
	logic        fint_ovf;
	logic [31:0] mag_a;
	logic [31:0] mag_b;

	always_comb begin
		add_w    = 33'(signed'(operand_a)) + 33'(signed'(operand_b));
		sub_w    = 33'(signed'(operand_a)) - 33'(signed'(operand_b));
		fint_top = operand_a[31:31-FB];
		// Conversion overflows when the bits shifted out differ from the sign.
		fint_ovf = !(&fint_top) && (|fint_top);
		mag_a    = operand_a[31] ? 32'(-operand_a) : 32'(operand_a);
		mag_b    = operand_b[31] ? 32'(-operand_b) : 32'(operand_b);

		side_d          = '0;
		side_d.less     = operand_a < operand_b;
		side_d.greater  = operand_a > operand_b;
		side_d.equal    = operand_a == operand_b;
		side_d.int_part = 24'(operand_a >>> FB);
		side_d.div_neg  = operand_a[31] ^ operand_b[31];
		side_d.div_zero = operand_b == 32'sd0;
		case (kind)
			KIND_ADD: begin
				side_d.ovf    = add_w[32] != add_w[31];
				side_d.result = side_d.ovf ? (add_w[32] ? SAT_MIN : SAT_MAX) : add_w[31:0];
			end
			KIND_SUB: begin
				side_d.ovf    = sub_w[32] != sub_w[31];
				side_d.result = side_d.ovf ? (sub_w[32] ? SAT_MIN : SAT_MAX) : sub_w[31:0];
			end
			KIND_MUL: side_d.is_mul = 1'b1;
			KIND_DIV: side_d.is_div = 1'b1;
			KIND_MIN: side_d.result = side_d.less ? operand_a : operand_b;
			KIND_MAX: side_d.result = side_d.greater ? operand_a : operand_b;
			KIND_INC: begin
				side_d.ovf    = operand_a == signed'(SAT_MAX);
				side_d.result = side_d.ovf ? SAT_MAX : 32'(operand_a + 32'sd1);
			end
			KIND_DEC: begin
				side_d.ovf    = operand_a == signed'(SAT_MIN);
				side_d.result = side_d.ovf ? SAT_MIN : 32'(operand_a - 32'sd1);
			end
			KIND_FINT: begin
				side_d.ovf    = fint_ovf;
				side_d.result = fint_ovf ? (operand_a[31] ? SAT_MIN : SAT_MAX)
					: 32'(operand_a <<< FB);
			end
			default: side_d.result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			prod_s1 <= 64'(operand_a) * 64'(operand_b);
			num_s1  <= NW'(mag_a) << FB;
			den_s1  <= mag_b;
		end
	end

endmodule

// ===== hw/rtl/fpa_div_step.sv =====
// One registered step of the restoring divider: one quotient bit per stage.
module fpa_div_step #(
	parameter int NW = 40
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num_in,
	input  logic [31:0]   rem_in,
	input  logic [NW-1:0] quo_in,
	input  logic [31:0]   den_in,
	output logic [NW-1:0] num_out,
	output logic [31:0]   rem_out,
	output logic [NW-1:0] quo_out,
	output logic [31:0]   den_out
);
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	always_comb begin
		trial = {rem_in, num_in[NW-1]};
		diff  = trial - {1'b0, den_in};
		ge    = trial >= {1'b0, den_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_out <= num_in << 1;
			rem_out <= ge ? diff[31:0] : trial[31:0];
			quo_out <= {quo_in[NW-2:0], ge};
			den_out <= den_in;
		end
	end

endmodule

// ===== hw/rtl/fixed_point_alu_q24_8_top.sv =====
// Top level of the signed fixed-point ALU with a pipelined restoring divider.
// Throughput is one item per cycle while no output stall holds the pipeline;
// depth is set by the divider, one quotient bit a stage.
// A stall at the output freezes the whole pipeline, so no item is lost or repeated.
// Reset clears all valid bits and the output valid; payload registers are not reset.
module fixed_point_alu_q24_8_top #(
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         kind,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_raw,
	output logic               a_less,
	output logic               a_greater,
	output logic               a_equal,
	output logic signed [23:0] integer_part,
	output logic               overflow,
	output logic               divide_by_zero
);
	import fpa_pkg::*;

	localparam int NW = 32 + FRACTION_BITS;

	logic               en;
	logic               valid_s1;
	side_t              side_s1;
	logic signed [63:0] prod_s1;
	logic [NW-1:0]      num_s1;
	logic [31:0]        den_s1;

	logic [NW-1:0] dnum [NW+1];
	logic [31:0]   drem [NW+1];
	logic [NW-1:0] dquo [NW+1];
	logic [31:0]   dden [NW+1];

	side_t         side_s2 [NW];
	logic [NW-1:0] valid_s2;
	side_t         side_mul;
	logic [63:0]   mul_sum;
	logic [63:0]   mul_mag;
	logic          mul_neg;
	logic          mul_ovf;

	side_t         fin;
	logic          div_rnd;
	logic [NW:0]   div_mag;
	logic          div_ovf;
	logic [31:0]   res_d;
	logic          ovf_d;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	fpa_front #(.FB(FRACTION_BITS), .NW(NW)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid), .kind(kind),
		.operand_a(operand_a), .operand_b(operand_b), .valid_s1(valid_s1),
		.side_s1(side_s1), .prod_s1(prod_s1), .num_s1(num_s1), .den_s1(den_s1)
	);

	assign dnum[0] = num_s1;
	assign drem[0] = '0;
	assign dquo[0] = '0;
	assign dden[0] = den_s1;

	for (genvar k = 0; k < NW; k++) begin : g_div
		fpa_div_step #(.NW(NW)) u_step (
			.clk(clk), .en(en),
			.num_in(dnum[k]), .rem_in(drem[k]), .quo_in(dquo[k]), .den_in(dden[k]),
			.num_out(dnum[k+1]), .rem_out(drem[k+1]), .quo_out(dquo[k+1]),
			.den_out(dden[k+1])
		);
	end

	// Multiply rounding: a negative product's magnitude plus the half step is half minus p.
	always_comb begin
		mul_neg = prod_s1[63];
		mul_sum = mul_neg ? (64'd1 << (FRACTION_BITS - 1)) - 64'(prod_s1)
			: 64'(prod_s1) + (64'd1 << (FRACTION_BITS - 1));
		mul_mag = mul_sum >> FRACTION_BITS;
		mul_ovf = mul_neg ? (mul_mag > 64'h8000_0000) : (mul_mag > 64'h7fff_ffff);
		side_mul = side_s1;
		if (side_s1.is_mul) begin
			side_mul.ovf    = mul_ovf;
			side_mul.result = mul_ovf ? (mul_neg ? SAT_MIN : SAT_MAX)
				: (mul_neg ? 32'(-mul_mag[31:0]) : mul_mag[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= '0;
		end else if (en) begin
			valid_s2 <= {valid_s2[NW-2:0], valid_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2[0] <= side_mul;
			for (int k = 1; k < NW; k++) begin
				side_s2[k] <= side_s2[k-1];
			end
		end
	end

	// Divide rounding: add one when twice the remainder reaches the divisor.
	always_comb begin
		fin     = side_s2[NW-1];
		div_rnd = {drem[NW], 1'b0} >= {1'b0, dden[NW]};
		div_mag = (NW+1)'(dquo[NW]) + (NW+1)'(div_rnd);
		div_ovf = fin.div_neg ? (div_mag > (NW+1)'(33'h1_0000_0000 >> 1))
			: (div_mag > (NW+1)'(SAT_MAX));
		res_d = fin.result;
		ovf_d = fin.ovf;
		if (fin.is_div) begin
			if (fin.div_zero) begin
				res_d = '0;
				ovf_d = 1'b0;
			end else begin
				ovf_d = div_ovf;
				res_d = div_ovf ? (fin.div_neg ? SAT_MIN : SAT_MAX)
					: (fin.div_neg ? 32'(-div_mag[31:0]) : div_mag[31:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s2[NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_raw     <= res_d;
			a_less         <= fin.less;
			a_greater      <= fin.greater;
			a_equal        <= fin.equal;
			integer_part   <= fin.int_part;
			overflow       <= ovf_d;
			divide_by_zero <= fin.is_div && fin.div_zero;
		end
	end

endmodule

// ===== hw/rtl/fpa_checker.sv =====
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result_raw,
	input logic        a_less,
	input logic        a_greater,
	input logic        a_equal,
	input logic        overflow,
	input logic        divide_by_zero
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_raw))
		else $error("stalled item changed");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled without output stall");

	a_cmp_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({a_less, a_greater, a_equal}) == 1)
		else $error("comparison flags not exclusive");

	a_dbz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_raw == 32'd0 && !overflow)
		else $error("zero divisor result wrong");
endmodule

bind fixed_point_alu_q24_8_top fpa_port_props u_fpa_port_props (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .result_raw(result_raw), .a_less(a_less),
	.a_greater(a_greater), .a_equal(a_equal), .overflow(overflow),
	.divide_by_zero(divide_by_zero)
);
